### hw/rtl/wrhp_pkg.sv
package wrhp_pkg;

  localparam int POSITION_BITS_DEF = 32;
  localparam int POS_EXT_W = 33;
  localparam int NEXT_W = 35;

  localparam logic [31:0] RIFF_TAG = 32'h52494646;
  localparam logic [31:0] WAVE_TAG = 32'h57415645;
  localparam logic [31:0] FMT_TAG = 32'h666D7420;
  localparam logic [31:0] DATA_TAG = 32'h64617461;
  localparam logic [31:0] FMT_BYTES = 32'd16;
  localparam logic [POS_EXT_W-1:0] MIN_FILE = POS_EXT_W'(44);
  localparam logic [15:0] FORMAT_PCM = 16'd1;
  localparam logic [15:0] PCM_BITS = 16'd16;
  localparam logic [15:0] CHANS_MONO = 16'd1;
  localparam logic [15:0] CHANS_STEREO = 16'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_SHORT = 3'd1;
  localparam logic [2:0] ST_BAD_TAG = 3'd2;
  localparam logic [2:0] ST_FMT_SHORT = 3'd3;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd4;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] sample_rate;
    logic        stereo;
    logic [31:0] data_offset;
    logic [31:0] data_length;
  } out_t;

  typedef struct packed {
    logic [POS_EXT_W-1:0] file_length;
    logic                 tags_ok;
    logic                 fmt_fault;
    logic [31:0]          format_length;
    logic [31:0]          data_length;
    logic [POS_EXT_W-1:0] data_offset;
    logic [15:0]          audio_format;
    logic [15:0]          channels;
    logic [31:0]          sample_rate;
    logic [15:0]          bits_per_sample;
  } snap_t;

  function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] i);
    logic [7:0] b;
    case (i)
      2'd0: b = tag[31:24];
      2'd1: b = tag[23:16];
      2'd2: b = tag[15:8];
      default: b = tag[7:0];
    endcase
    return b;
  endfunction

endpackage

### hw/rtl/wrhp_walker.sv
module wrhp_walker #(
  parameter int POSITION_BITS = wrhp_pkg::POSITION_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  wrhp_pkg::in_t   in_data,
  output logic            snap_valid,
  input  logic            snap_ready,
  output wrhp_pkg::snap_t snap
);
  import wrhp_pkg::*;

  localparam int PW = POSITION_BITS;
  localparam int CW = POSITION_BITS + 1;

  typedef enum logic [4:0] {
    PH_RIFF     = 5'b00001,
    PH_HDR      = 5'b00010,
    PH_FMT      = 5'b00100,
    PH_DONE     = 5'b01000,
    PH_FMT_FAIL = 5'b10000
  } phase_t;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_final;
  logic        s1_adv;

  logic [CW-1:0] byte_count, byte_count_next;
  logic          tags_ok, tags_ok_next;
  phase_t        phase, phase_next;
  logic [PW-1:0] chunk_start, chunk_start_next;
  logic [31:0]   chunk_tag, chunk_tag_next;
  logic [31:0]   chunk_length, chunk_length_next;
  logic [7:0]    fmt [16];
  logic [7:0]    fmt_next [16];
  logic [31:0]   format_length, format_length_next;
  logic [3:0]    fmt_seen, fmt_seen_next;
  logic [31:0]   data_length, data_length_next;
  logic [CW-1:0] data_offset, data_offset_next;
  logic          walk_done, walk_done_next;

  logic [CW-1:0]     k;
  logic [32:0]       rounded;
  logic [NEXT_W-1:0] next_pos;
  logic              is_fmt;
  logic              is_data;
  snap_t             snap_next;

  assign s1_adv = s1_valid && (!s1_final || !snap_valid || snap_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_comb begin
    byte_count_next = byte_count;
    tags_ok_next = tags_ok;
    phase_next = phase;
    chunk_start_next = chunk_start;
    chunk_tag_next = chunk_tag;
    chunk_length_next = chunk_length;
    fmt_next = fmt;
    format_length_next = format_length;
    fmt_seen_next = fmt_seen;
    data_length_next = data_length;
    data_offset_next = data_offset;
    walk_done_next = walk_done;
    k = byte_count - CW'(chunk_start);
    rounded = '0;
    next_pos = '0;
    is_fmt = 1'b0;
    is_data = 1'b0;
    if (!byte_count[PW]) begin
      byte_count_next = byte_count + 1'b1;
      unique case (phase)
        PH_RIFF: begin
          if (byte_count[3:2] == 2'd0 &&
              s1_byte != tag_byte(RIFF_TAG, byte_count[1:0])) begin
            tags_ok_next = 1'b0;
          end
          if (byte_count[3:2] == 2'd2 &&
              s1_byte != tag_byte(WAVE_TAG, byte_count[1:0])) begin
            tags_ok_next = 1'b0;
          end
          if (byte_count[3:0] == 4'd11) begin
            phase_next = PH_HDR;
          end
        end
        PH_HDR: begin
          if (byte_count >= CW'(chunk_start) && k[CW-1:3] == '0) begin
            if (!k[2]) begin
              chunk_tag_next = {chunk_tag[23:0], s1_byte};
            end else begin
              chunk_length_next = chunk_length | (32'(s1_byte) << {k[1:0], 3'b000});
            end
            if (k[2:0] == 3'd7) begin
              is_fmt = chunk_tag == FMT_TAG;
              is_data = chunk_tag == DATA_TAG;
              rounded = ({1'b0, chunk_length_next} + 33'd1) & ~33'd1;
              next_pos = NEXT_W'(chunk_start) + NEXT_W'(8) + NEXT_W'(rounded);
              if (is_fmt && chunk_length_next < FMT_BYTES) begin
                format_length_next = chunk_length_next;
                phase_next = PH_FMT_FAIL;
              end else begin
                if (is_fmt) begin
                  format_length_next = chunk_length_next;
                  fmt_seen_next = '0;
                end else if (is_data) begin
                  data_length_next = chunk_length_next;
                  data_offset_next = CW'(chunk_start) + CW'(8);
                end
                if (next_pos[NEXT_W-1:PW] != '0) begin
                  walk_done_next = 1'b1;
                end else begin
                  chunk_start_next = next_pos[PW-1:0];
                  if (format_length_next != '0 && data_length_next != '0) begin
                    walk_done_next = 1'b1;
                  end
                end
                chunk_tag_next = '0;
                chunk_length_next = '0;
                if (is_fmt) begin
                  phase_next = PH_FMT;
                end else begin
                  phase_next = walk_done_next ? PH_DONE : PH_HDR;
                end
              end
            end
          end
        end
        PH_FMT: begin
          fmt_next[fmt_seen] = s1_byte;
          fmt_seen_next = fmt_seen + 1'b1;
          if (fmt_seen == 4'd15) begin
            phase_next = walk_done ? PH_DONE : PH_HDR;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    snap_next.file_length = POS_EXT_W'(byte_count_next);
    snap_next.tags_ok = tags_ok_next;
    snap_next.fmt_fault = (phase_next == PH_FMT_FAIL) || (phase_next == PH_FMT);
    snap_next.format_length = format_length_next;
    snap_next.data_length = data_length_next;
    snap_next.data_offset = POS_EXT_W'(data_offset_next);
    snap_next.audio_format = {fmt_next[1], fmt_next[0]};
    snap_next.channels = {fmt_next[3], fmt_next[2]};
    snap_next.sample_rate = {fmt_next[7], fmt_next[6], fmt_next[5], fmt_next[4]};
    snap_next.bits_per_sample = {fmt_next[15], fmt_next[14]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_byte <= in_data.file_byte;
      s1_final <= in_data.final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (s1_adv && s1_final)) begin
      byte_count <= '0;
      tags_ok <= 1'b1;
      phase <= PH_RIFF;
      chunk_start <= PW'(12);
      chunk_tag <= '0;
      chunk_length <= '0;
      for (int i = 0; i < 16; i++) begin
        fmt[i] <= '0;
      end
      format_length <= '0;
      fmt_seen <= '0;
      data_length <= '0;
      data_offset <= '0;
      walk_done <= 1'b0;
    end else if (s1_adv) begin
      byte_count <= byte_count_next;
      tags_ok <= tags_ok_next;
      phase <= phase_next;
      chunk_start <= chunk_start_next;
      chunk_tag <= chunk_tag_next;
      chunk_length <= chunk_length_next;
      fmt <= fmt_next;
      format_length <= format_length_next;
      fmt_seen <= fmt_seen_next;
      data_length <= data_length_next;
      data_offset <= data_offset_next;
      walk_done <= walk_done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (s1_adv && s1_final) begin
      snap_valid <= 1'b1;
    end else if (snap_ready) begin
      snap_valid <= 1'b0;
    end
    if (s1_adv && s1_final) begin
      snap <= snap_next;
    end
  end

endmodule

### hw/rtl/wrhp_result.sv
module wrhp_result (
  input  logic            clk,
  input  logic            rst,
  input  logic            snap_valid,
  output logic            snap_ready,
  input  wrhp_pkg::snap_t snap,
  output logic            out_valid,
  input  logic            out_ready,
  output wrhp_pkg::out_t  out_data
);
  import wrhp_pkg::*;

  logic [2:0]           status;
  logic [POS_EXT_W:0]   data_end;
  logic                 clip;
  logic [POS_EXT_W-1:0] tail;
  logic                 bad_format;
  out_t                 out_next;

  assign snap_ready = !out_valid || out_ready;

  always_comb begin
    bad_format = snap.audio_format != FORMAT_PCM || snap.bits_per_sample != PCM_BITS ||
                 snap.sample_rate == '0 ||
                 (snap.channels != CHANS_MONO && snap.channels != CHANS_STEREO);
    if (snap.file_length < MIN_FILE) begin
      status = ST_SHORT;
    end else if (!snap.tags_ok) begin
      status = ST_BAD_TAG;
    end else if (snap.fmt_fault) begin
      status = ST_FMT_SHORT;
    end else if (snap.format_length < FMT_BYTES || snap.data_length == '0 ||
                 snap.data_offset == '0 || bad_format) begin
      status = ST_UNSUPPORTED;
    end else begin
      status = ST_OK;
    end
    data_end = {1'b0, snap.data_offset} + (POS_EXT_W + 1)'(snap.data_length);
    clip = data_end > {1'b0, snap.file_length};
    tail = snap.file_length - snap.data_offset;
    out_next.status = status;
    if (status == ST_OK) begin
      out_next.sample_rate = snap.sample_rate;
      out_next.stereo = snap.channels == CHANS_STEREO;
      out_next.data_offset = snap.data_offset[31:0];
      out_next.data_length = clip ? tail[31:0] : snap.data_length;
    end else begin
      out_next.sample_rate = '0;
      out_next.stereo = 1'b0;
      out_next.data_offset = '0;
      out_next.data_length = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_ready) begin
      out_valid <= snap_valid;
    end
    if (snap_ready && snap_valid) begin
      out_data <= out_next;
    end
  end

endmodule

### hw/rtl/wav_riff_header_parser.sv
// Throughput: one file byte per cycle, back to back, across file boundaries,
//   unless a final byte waits on a full snapshot register. The result passes
//   the input register, header snapshot register and result register in turn.
// Reset (rst, synchronous): drops all pending work and restarts the parse at
//   file offset zero; the parser also restarts by itself after each final byte.
module wav_riff_header_parser #(
  parameter int POSITION_BITS = wrhp_pkg::POSITION_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  wrhp_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output wrhp_pkg::out_t out_data
);
  import wrhp_pkg::*;

  logic  snap_valid;
  logic  snap_ready;
  snap_t snap;

  wrhp_walker #(
    .POSITION_BITS(POSITION_BITS)
  ) u_walker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .snap_valid(snap_valid),
    .snap_ready(snap_ready),
    .snap      (snap)
  );

  wrhp_result u_result (
    .clk       (clk),
    .rst       (rst),
    .snap_valid(snap_valid),
    .snap_ready(snap_ready),
    .snap      (snap),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
